[rtl/core/lsrb_pkg.sv]
// shared types and constants of the led segment refresh block
// no dependencies; imported by lsrb_cfg, lsrb_seq and the top level
package lsrb_pkg;

  // function codes of an input beat
  localparam logic [2:0] FUNC_WR_SEG  = 3'd0;
  localparam logic [2:0] FUNC_WR_MASK = 3'd1;
  localparam logic [2:0] FUNC_TOGGLE  = 3'd2;
  localparam logic [2:0] FUNC_FILL    = 3'd3;
  localparam logic [2:0] FUNC_REFRESH = 3'd4;
  localparam logic [2:0] FUNC_MODE    = 3'd5;
  localparam logic [2:0] FUNC_ENABLE  = 3'd6;

  // configuration register indexes (paddr bit 2)
  localparam logic REG_BRIGHTNESS = 1'b0;
  localparam logic REG_MODE       = 1'b1;

  localparam logic [2:0] BRIGHTNESS_RST = 3'd0;
  localparam logic [1:0] MODE_RST       = 2'd3;

  // wire bytes
  localparam logic [7:0] CMD_WRITE_SINGLE = 8'h44;
  localparam logic [7:0] CMD_ADDRESS      = 8'hC0;
  localparam logic [7:0] CMD_ENABLE       = 8'h88;
  localparam logic [7:0] MASK_FULL        = 8'hFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REFRESH,
    ST_BCAST
  } lsrb_state_e;

  // buffer read request from the sequencer
  typedef struct packed {
    logic       en;
    logic [2:0] chip;
    logic [2:0] grid;
  } lsrb_rd_req_t;

  // one result beat
  typedef struct packed {
    logic       strobe;
    logic [2:0] target_chip;
    logic [7:0] wire_byte;
    logic       release_strobe;
    logic       last;
  } lsrb_beat_t;

endpackage

[rtl/core/lsrb_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module lsrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 35,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/lsrb_cfg.sv]
// apb register file: brightness and display mode
// depends on lsrb_pkg
module lsrb_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [2:0]  brightness_o,
  output logic [1:0]  display_mode_o
);
  import lsrb_pkg::*;

  logic [2:0] brightness_q, brightness_d;
  logic [1:0] mode_q, mode_d;
  logic       wr_en;
  logic       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[2];

  always_comb begin
    brightness_d = brightness_q;
    mode_d       = mode_q;
    if (wr_en) begin
      case (reg_idx)
        REG_BRIGHTNESS: brightness_d = pwdata[2:0];
        REG_MODE:       mode_d       = pwdata[1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BRIGHTNESS: prdata = {29'd0, brightness_q};
      REG_MODE:       prdata = {30'd0, mode_q};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= BRIGHTNESS_RST;
      mode_q       <= MODE_RST;
    end else begin
      brightness_q <= brightness_d;
      mode_q       <= mode_d;
    end
  end

  assign brightness_o   = brightness_q;
  assign display_mode_o = mode_q;

endmodule

[rtl/core/lsrb_seq.sv]
// refresh and broadcast sequencer with registered result beat
// depends on lsrb_pkg
module lsrb_seq #(
  parameter int unsigned CHIPS = 5,
  parameter int unsigned GRIDS = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [2:0]             func_i,
  input  logic [2:0]             chip_i,
  input  logic                   chip_ok_i,
  input  logic [2:0]             brightness_i,
  input  logic [1:0]             display_mode_i,
  input  logic [7:0]             data_i,
  output logic                   busy_o,
  output lsrb_pkg::lsrb_rd_req_t rd_req_o,
  output lsrb_pkg::lsrb_beat_t   beat_o
);
  import lsrb_pkg::*;

  localparam logic [2:0] LastGrid = 3'(GRIDS - 1);
  localparam logic [2:0] LastChip = 3'(CHIPS - 1);

  lsrb_state_e state_q, state_d;
  logic [1:0]  phase_q, phase_d;
  logic [2:0]  grid_q, grid_d;
  logic [2:0]  chip_q, chip_d;
  logic [7:0]  cmd_q, cmd_d;
  lsrb_beat_t  beat_q, beat_d;

  // next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    grid_d  = grid_q;
    chip_d  = chip_q;
    cmd_d   = cmd_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          if (func_i == FUNC_REFRESH && chip_ok_i) begin
            state_d = ST_REFRESH;
            phase_d = 2'd0;
            grid_d  = 3'd0;
            chip_d  = chip_i;
          end else if (func_i == FUNC_MODE) begin
            state_d = ST_BCAST;
            chip_d  = 3'd0;
            cmd_d   = {6'd0, display_mode_i};
          end else if (func_i == FUNC_ENABLE) begin
            state_d = ST_BCAST;
            chip_d  = 3'd0;
            cmd_d   = CMD_ENABLE | {5'd0, brightness_i};
          end
        end
      end
      ST_REFRESH: begin
        if (phase_q == 2'd2) begin
          phase_d = 2'd0;
          if (grid_q == LastGrid) begin
            state_d = ST_IDLE;
          end else begin
            grid_d = grid_q + 3'd1;
          end
        end else begin
          phase_d = phase_q + 2'd1;
        end
      end
      ST_BCAST: begin
        if (chip_q == LastChip) begin
          state_d = ST_IDLE;
        end else begin
          chip_d = chip_q + 3'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs: read request and the beat to register
  always_comb begin
    rd_req_o      = '0;
    rd_req_o.chip = chip_q;
    rd_req_o.grid = grid_q;
    beat_d        = '0;
    beat_d.target_chip = chip_q;
    case (state_q)
      ST_REFRESH: begin
        beat_d.strobe = 1'b1;
        case (phase_q)
          2'd0: begin
            // buffer read issued here, data back for phase two
            rd_req_o.en           = 1'b1;
            beat_d.wire_byte      = CMD_WRITE_SINGLE;
            beat_d.release_strobe = 1'b1;
          end
          2'd1: begin
            beat_d.wire_byte      = CMD_ADDRESS | {4'd0, grid_q, 1'b0};
            beat_d.release_strobe = 1'b0;
          end
          default: begin
            beat_d.wire_byte      = data_i;
            beat_d.release_strobe = 1'b1;
            beat_d.last           = (grid_q == LastGrid);
          end
        endcase
      end
      ST_BCAST: begin
        beat_d.strobe         = 1'b1;
        beat_d.wire_byte      = cmd_q;
        beat_d.release_strobe = 1'b1;
        beat_d.last           = (chip_q == LastChip);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 2'd0;
      grid_q  <= 3'd0;
      chip_q  <= 3'd0;
      cmd_q   <= 8'd0;
      beat_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      grid_q  <= grid_d;
      chip_q  <= chip_d;
      cmd_q   <= cmd_d;
      beat_q  <= beat_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign beat_o = beat_q;

endmodule

[rtl/core/led_segment_refresh_with_blink_core.sv]
// top level of the led segment refresh block: buffers, valid bits, blink phase
// depends on lsrb_pkg, lsrb_ram, lsrb_cfg, lsrb_seq
//
// Usage:
//   Commands enter on start/busy: a beat is taken at a rising edge with start
//   high and busy low. func picks the operation; chip, grid and value carry
//   its operands. Segment and mask writes, blink toggle and fill produce no
//   results.
//   A chip refresh streams 3*GRIDS bytes (write command, grid address, data)
//   and a mode or enable broadcast streams CHIPS bytes, one per cycle. busy
//   stays high from the accepting edge until the last byte is out, so a new
//   command waits for it; the command rate is set by the one-byte-per-cycle
//   sequencer and its one buffer read per grid.
//   Result beats show on out_strobe_o for one cycle each, the first after the
//   state and beat registers of the sequencer; the receiver cannot stall them.
//   The segment and mask buffers are rams with registered read data; reset
//   clears the per-entry valid bits, so unwritten entries read as zero (or
//   the fill value and a full mask after a fill), with no clearing pass.
//   Registers sit on the apb port: brightness at 0x0, display mode at 0x4.
module led_segment_refresh_with_blink_core #(
  parameter int unsigned CHIPS = 5,
  parameter int unsigned GRIDS = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func_i,
  input  logic [2:0]  chip_i,
  input  logic [2:0]  grid_i,
  input  logic [7:0]  value_i,
  output logic        out_strobe_o,
  output logic [2:0]  target_chip_o,
  output logic [7:0]  wire_byte_o,
  output logic        release_strobe_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lsrb_pkg::*;

  localparam int unsigned Depth = CHIPS * GRIDS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic             accept;
  logic             chip_ok;
  logic             grid_ok;
  logic             wr_ok;
  logic             seg_we;
  logic             msk_we;
  logic             fill;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;
  logic [7:0]       seg_rdata;
  logic [7:0]       msk_rdata;
  logic [7:0]       seg_val;
  logic [7:0]       msk_val;
  logic [7:0]       data;
  logic [2:0]       brightness;
  logic [1:0]       display_mode;
  lsrb_rd_req_t     rd_req;
  lsrb_beat_t       beat;

  logic [Depth-1:0] seg_vld_q, seg_vld_d;
  logic [Depth-1:0] msk_vld_q, msk_vld_d;
  logic             seg_vld_rd_q, msk_vld_rd_q;
  logic [7:0]       dflt_seg_q, dflt_seg_d;
  logic [7:0]       dflt_msk_q, dflt_msk_d;
  logic             blink_q, blink_d;

  assign accept  = start & ~busy;
  assign chip_ok = {1'b0, chip_i} < 4'(CHIPS);
  assign grid_ok = {1'b0, grid_i} < 4'(GRIDS);
  assign wr_ok   = accept & chip_ok & grid_ok;
  assign seg_we  = wr_ok & (func_i == FUNC_WR_SEG);
  assign msk_we  = wr_ok & (func_i == FUNC_WR_MASK);
  assign fill    = accept & (func_i == FUNC_FILL);

  assign waddr = AddrW'(32'(chip_i) * GRIDS + 32'(grid_i));
  assign raddr = AddrW'(32'(rd_req.chip) * GRIDS + 32'(rd_req.grid));

  lsrb_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .brightness_o   (brightness),
    .display_mode_o (display_mode)
  );

  lsrb_ram #(.WIDTH(8), .DEPTH(Depth)) u_seg_ram (
    .clk_i,
    .we_i    (seg_we),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (rd_req.en),
    .raddr_i (raddr),
    .rdata_o (seg_rdata)
  );

  lsrb_ram #(.WIDTH(8), .DEPTH(Depth)) u_msk_ram (
    .clk_i,
    .we_i    (msk_we),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (rd_req.en),
    .raddr_i (raddr),
    .rdata_o (msk_rdata)
  );

  // an entry not written since reset or the last fill reads the default
  always_comb begin
    seg_vld_d  = seg_vld_q;
    msk_vld_d  = msk_vld_q;
    dflt_seg_d = dflt_seg_q;
    dflt_msk_d = dflt_msk_q;
    blink_d    = blink_q;
    if (fill) begin
      seg_vld_d  = '0;
      msk_vld_d  = '0;
      dflt_seg_d = value_i;
      dflt_msk_d = MASK_FULL;
    end
    if (seg_we) begin
      seg_vld_d[waddr] = 1'b1;
    end
    if (msk_we) begin
      msk_vld_d[waddr] = 1'b1;
    end
    if (accept && func_i == FUNC_TOGGLE) begin
      blink_d = ~blink_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_vld_q  <= '0;
      msk_vld_q  <= '0;
      dflt_seg_q <= 8'd0;
      dflt_msk_q <= 8'd0;
      blink_q    <= 1'b0;
    end else begin
      seg_vld_q  <= seg_vld_d;
      msk_vld_q  <= msk_vld_d;
      dflt_seg_q <= dflt_seg_d;
      dflt_msk_q <= dflt_msk_d;
      blink_q    <= blink_d;
    end
  end

  // valid bits sampled alongside the ram read
  always_ff @(posedge clk_i) begin
    if (rd_req.en) begin
      seg_vld_rd_q <= seg_vld_q[raddr];
      msk_vld_rd_q <= msk_vld_q[raddr];
    end
  end

  assign seg_val = seg_vld_rd_q ? seg_rdata : dflt_seg_q;
  assign msk_val = msk_vld_rd_q ? msk_rdata : dflt_msk_q;
  assign data    = (blink_q && msk_val != MASK_FULL) ? (msk_val & seg_val) : seg_val;

  lsrb_seq #(.CHIPS(CHIPS), .GRIDS(GRIDS)) u_seq (
    .clk_i,
    .rst_ni,
    .accept_i       (accept),
    .func_i,
    .chip_i,
    .chip_ok_i      (chip_ok),
    .brightness_i   (brightness),
    .display_mode_i (display_mode),
    .data_i         (data),
    .busy_o         (busy),
    .rd_req_o       (rd_req),
    .beat_o         (beat)
  );

  assign out_strobe_o     = beat.strobe;
  assign target_chip_o    = beat.target_chip;
  assign wire_byte_o      = beat.wire_byte;
  assign release_strobe_o = beat.release_strobe;
  assign last_o           = beat.last;

endmodule
